@@ hdl/cwt_pkg.sv @@
package cwt_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [1:0] ROLE_SKIP  = 2'd0;
    localparam logic [1:0] ROLE_START = 2'd1;
    localparam logic [1:0] ROLE_CONT  = 2'd2;

    typedef struct packed {
        logic [20:0] codepoint;
        logic        text_last;
    } t_in;

    typedef struct packed {
        logic [20:0] out_codepoint;
        logic [20:0] folded_codepoint;
        logic [1:0]  role;
        logic        run_last;
        logic        text_end;
    } t_out;

    typedef struct packed {
        logic cjk;
        logic sigil;
        logic word;
        logic digit;
        logic dot;
    } t_cp_class;

    typedef struct packed {
        logic [1:0] cnt;
        t_out       res0;
        t_out       res1;
    } t_push;

endpackage

@@ hdl/cwt_class.sv @@
module cwt_class (
    input  logic [20:0]          i_cp,
    output cwt_pkg::t_cp_class   o_class
);

    localparam int NSPAN = 7;
    localparam logic [20:0] CJK_LO [NSPAN] = '{21'h03040, 21'h031F0, 21'h03400, 21'h04E00,
                                               21'h0F900, 21'h0FF66, 21'h20000};
    localparam logic [20:0] CJK_HI [NSPAN] = '{21'h030FF, 21'h031FF, 21'h04DBF, 21'h09FFF,
                                               21'h0FAFF, 21'h0FF9F, 21'h2FA1F};
    localparam logic [20:0] SYM_LO [NSPAN] = '{21'h02000, 21'h02190, 21'h03000, 21'h0FE00,
                                               21'h0FF01, 21'h0FFA0, 21'h1F000};
    localparam logic [20:0] SYM_HI [NSPAN] = '{21'h0206F, 21'h02BFF, 21'h0303F, 21'h0FE6F,
                                               21'h0FF65, 21'h0FFFF, 21'h1FFFF};

    logic cjk;
    logic sym;
    logic digit;
    logic ascii_word;

    always_comb begin
        cjk = 1'b0;
        sym = 1'b0;
        for (int i = 0; i < NSPAN; i++) begin
            if (i_cp >= CJK_LO[i] && i_cp <= CJK_HI[i]) begin
                cjk = 1'b1;
            end
            if (i_cp >= SYM_LO[i] && i_cp <= SYM_HI[i]) begin
                sym = 1'b1;
            end
        end
    end

    assign digit      = (i_cp >= 21'h30) && (i_cp <= 21'h39);
    assign ascii_word = ((i_cp >= 21'h41) && (i_cp <= 21'h5A)) ||
                        ((i_cp >= 21'h61) && (i_cp <= 21'h7A)) ||
                        digit || (i_cp == 21'h5F) || (i_cp == 21'h27) || (i_cp == 21'h2D);

    assign o_class.cjk   = cjk;
    assign o_class.sigil = (i_cp == 21'h40) || (i_cp == 21'h23);
    assign o_class.digit = digit;
    assign o_class.dot   = (i_cp == 21'h2E);
    assign o_class.word  = (i_cp < 21'h80) ? ascii_word : (!cjk && !sym);

endmodule

@@ hdl/cwt_scan.sv @@
module cwt_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cwt_pkg::t_in    i_data,
    input  logic            i_space,
    output cwt_pkg::t_push  o_push
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_DEC  = 3'd2,
        MODE_HSIG = 3'd3,
        MODE_HDOT = 3'd4
    } t_mode;

    logic               r_valid;
    cwt_pkg::t_in       r_in;
    t_mode              r_mode;
    t_mode              n_mode;
    logic [20:0]        r_held;
    logic [20:0]        n_held;
    cwt_pkg::t_cp_class cls;
    logic               advance;
    logic [20:0]        c;
    logic               last;

    logic               idle_emit;
    logic [1:0]         idle_role;
    t_mode              idle_mode;
    logic               pre_en;
    logic [1:0]         pre_role;
    logic               main_en;
    logic [1:0]         main_role;
    t_mode              step_mode;

    function automatic logic [20:0] fold(input logic [20:0] cp);
        logic [20:0] f;
        f = cp;
        if (cp >= 21'h41 && cp <= 21'h5A) begin
            f = cp + 21'h20;
        end else if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7) begin
            f = cp + 21'h20;
        end else if (cp >= 21'h410 && cp <= 21'h42F) begin
            f = cp + 21'h20;
        end else if (cp >= 21'h400 && cp <= 21'h40F) begin
            f = cp + 21'h50;
        end
        return f;
    endfunction

    function automatic cwt_pkg::t_out make_res(input logic [20:0] cp, input logic [1:0] role,
                                               input logic run_last, input logic text_end);
        cwt_pkg::t_out r;
        r.out_codepoint    = cp;
        r.folded_codepoint = fold(cp);
        r.role             = role;
        r.run_last         = run_last;
        r.text_end         = text_end;
        return r;
    endfunction

    cwt_class u_class (
        .i_cp    (r_in.codepoint),
        .o_class (cls)
    );

    assign c       = r_in.codepoint;
    assign last    = r_in.text_last;
    assign advance = r_valid && i_space;
    assign o_ready = !r_valid || advance;

    always_comb begin
        idle_emit = 1'b1;
        idle_role = cwt_pkg::ROLE_SKIP;
        idle_mode = MODE_IDLE;
        if (cls.cjk) begin
            idle_role = cwt_pkg::ROLE_START;
        end else if (cls.sigil) begin
            if (!last) begin
                idle_emit = 1'b0;
                idle_mode = MODE_HSIG;
            end
        end else if (cls.word) begin
            idle_role = cwt_pkg::ROLE_START;
            idle_mode = MODE_WORD;
        end
    end

    always_comb begin
        pre_en    = 1'b0;
        pre_role  = cwt_pkg::ROLE_SKIP;
        main_en   = idle_emit;
        main_role = idle_role;
        step_mode = idle_mode;
        case (r_mode)
            MODE_WORD: begin
                if (cls.word) begin
                    main_en   = 1'b1;
                    main_role = cwt_pkg::ROLE_CONT;
                    step_mode = MODE_WORD;
                end else if (cls.dot && !last) begin
                    main_en   = 1'b0;
                    step_mode = MODE_HDOT;
                end
            end
            MODE_DEC: begin
                if (cls.digit) begin
                    main_en   = 1'b1;
                    main_role = cwt_pkg::ROLE_CONT;
                    step_mode = MODE_DEC;
                end
            end
            MODE_HSIG: begin
                pre_en = 1'b1;
                if (cls.word) begin
                    pre_role  = cwt_pkg::ROLE_START;
                    main_en   = 1'b1;
                    main_role = cwt_pkg::ROLE_CONT;
                    step_mode = MODE_WORD;
                end
            end
            MODE_HDOT: begin
                pre_en = 1'b1;
                if (cls.digit) begin
                    pre_role  = cwt_pkg::ROLE_CONT;
                    main_en   = 1'b1;
                    main_role = cwt_pkg::ROLE_CONT;
                    step_mode = MODE_DEC;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_mode = step_mode;
        n_held = 21'd0;
        if (step_mode == MODE_HSIG || step_mode == MODE_HDOT) begin
            n_held = c;
        end
        if (last) begin
            n_mode = MODE_IDLE;
            n_held = 21'd0;
        end
    end

    always_comb begin
        o_push.cnt  = advance ? ({1'b0, pre_en} + {1'b0, main_en}) : 2'd0;
        o_push.res1 = make_res(c, main_role, 1'b1, last);
        if (pre_en) begin
            o_push.res0 = make_res(r_held, pre_role, !main_en, last && !main_en);
        end else begin
            o_push.res0 = make_res(c, main_role, 1'b1, last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_held  <= 21'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (advance) begin
                r_mode <= n_mode;
                r_held <= n_held;
            end
        end
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    a_hold_sigil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HSIG) |-> (r_held == 21'h40 || r_held == 21'h23))
        else $error("held codepoint is not a sigil");

    a_empty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && o_push.cnt == 2'd0) |=> (r_mode == MODE_HSIG || r_mode == MODE_HDOT))
        else $error("word dropped without holding a codepoint");

endmodule

@@ hdl/cwt_fifo.sv @@
module cwt_fifo #(
    parameter int unsigned DEPTH = cwt_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cwt_pkg::t_push  i_push,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_ready,
    output cwt_pkg::t_out   o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cwt_pkg::t_out r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wr1;
    logic          pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr1     = inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_space = (r_count <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.cnt == 2'd1) begin
                r_wr <= wr1;
            end else if (i_push.cnt == 2'd2) begin
                r_wr <= inc(wr1);
            end
            if (pop) begin
                r_rd <= inc(r_rd);
            end
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space)
        else $error("push without room");

endmodule

@@ hdl/codepoint_word_tokenizer.sv @@
// channel  direction  valid     ready     payload
// input    in         i_valid   o_ready   i_data (codepoint, text_last)
// output   out        o_valid   i_ready   o_data (codepoint, fold, role, run/text end)
//
// One input word is taken per cycle while the result queue has room; it yields zero,
// one or two output words. An input word is held in the input register, is labelled,
// and its results then enter the result queue. A two-result step always follows a held
// step, so with FifoDepth of at least 4 a ready receiver never stalls input.
// Reset (synchronous, active low) empties the queue and returns the scanner to idle.
// Input stalls only while the queue holds more than FifoDepth - 2 results.
module codepoint_word_tokenizer #(
    parameter int unsigned FifoDepth = cwt_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cwt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cwt_pkg::t_out o_data
);

    cwt_pkg::t_push push;
    logic           space;

    cwt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_space (space),
        .o_push  (push)
    );

    cwt_fifo #(
        .DEPTH (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
